/* sv/tsa_pkg.sv */
// Package for the timestamp set assembler: field widths, status and register
// codes, the item and result structs, and the small pointer modulo table.
// Has no dependencies; every other file of the block refers to it by scope.
package tsa_pkg;

  localparam int unsigned STAMP_W    = 63;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned OUT_MASK_W = 8;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  // The depth register is four bits wide, so no more than this many ring
  // entries can ever be in use.
  localparam int unsigned MAX_DEPTH = 15;
  localparam int unsigned MAX_TYPES = 15;

  localparam int unsigned RING_DEPTH_DEF = 8;
  localparam int unsigned TYPE_COUNT_DEF = 8;

  localparam logic [CFG_W-1:0] TYPES_RESET = 4'd8;
  localparam logic [CFG_W-1:0] DEPTH_RESET = 4'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_PARTIAL   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_LATE      = 3'd3,
    ST_BAD_SLOT  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPES_IN_USE  = 2'd0,
    CFG_HISTORY_DEPTH = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SLOT_W-1:0]  slot;
  } item_t;

  typedef struct packed {
    status_e               status;
    logic [IDX_W-1:0]      entry_index;
    logic [OUT_MASK_W-1:0] set_mask;
    logic                  evicted;
    logic [STAMP_W-1:0]    evicted_stamp;
    logic [OUT_MASK_W-1:0] evicted_mask;
  } result_t;

  // Table of a mod b for four-bit a and b, indexed by {a, b}. Built at
  // elaboration by repeated subtraction; b of zero is never looked up.
  typedef logic [CFG_W-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_table();
    mod_tab_t tab;
    int unsigned r;
    for (int unsigned a = 0; a < 16; a++) begin
      for (int unsigned b = 0; b < 16; b++) begin
        r = a;
        for (int unsigned s = 0; s < 16; s++) begin
          if (b != 0 && r >= b) begin
            r = r - b;
          end
        end
        tab[a * 16 + b] = CFG_W'(r);
      end
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TABLE = build_mod_table();

endpackage

/* sv/timestamp_set_assembler.sv */
// Words pass from the input register through the combinational ring lookup to the
// registered ring update and output register; one word per cycle while results are taken.
// The output register lets a new word enter while a result waits to be taken.
// Reset (rst_ni low, asynchronous): all entries empty, pointer at entry 0,
// types_in_use 8, history_depth 5, both stages empty. Depends on tsa_pkg, tsa_ring.
module timestamp_set_assembler #(
  parameter int unsigned RING_DEPTH = tsa_pkg::RING_DEPTH_DEF,
  parameter int unsigned TYPE_COUNT = tsa_pkg::TYPE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tsa_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tsa_pkg::STAMP_W-1:0]       timestamp_i,
  input  logic [tsa_pkg::SLOT_W-1:0]        type_slot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tsa_pkg::STATUS_W-1:0]      status_o,
  output logic [tsa_pkg::IDX_W-1:0]         entry_index_o,
  output logic [tsa_pkg::OUT_MASK_W-1:0]    set_mask_o,
  output logic                              evicted_o,
  output logic [tsa_pkg::STAMP_W-1:0]       evicted_stamp_o,
  output logic [tsa_pkg::OUT_MASK_W-1:0]    evicted_mask_o
);

  // Configuration registers, stored raw; clamping happens in the ring.
  logic [tsa_pkg::CFG_W-1:0] types_q, depth_q;

  // Input register: holds one accepted word until the ring processes it.
  logic           in_vq;
  tsa_pkg::item_t item_q;

  // Output register: holds one result until the consumer takes it.
  logic             out_vq;
  tsa_pkg::result_t res_q;
  tsa_pkg::result_t res_d;

  logic step;

  // The ring processes the held word whenever the output register is free
  // or is being emptied in this same cycle. The input side then refills.
  assign step       = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      types_q <= tsa_pkg::TYPES_RESET;
      depth_q <= tsa_pkg::DEPTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsa_pkg::CFG_TYPES_IN_USE:  types_q <= cfg_data_i;
        tsa_pkg::CFG_HISTORY_DEPTH: depth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.stamp <= timestamp_i;
      item_q.slot  <= type_slot_i;
    end
  end

  tsa_ring #(
    .RING_DEPTH (RING_DEPTH),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_ring (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (item_q),
    .types_in_use_i  (types_q),
    .history_depth_i (depth_q),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (step) begin
      out_vq <= 1'b1;
    end else if (out_ready_i) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vq;
  assign status_o        = res_q.status;
  assign entry_index_o   = res_q.entry_index;
  assign set_mask_o      = res_q.set_mask;
  assign evicted_o       = res_q.evicted;
  assign evicted_stamp_o = res_q.evicted_stamp;
  assign evicted_mask_o  = res_q.evicted_mask;

  a_step_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vq)
    else $error("processed word produced no result");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && !step |=> in_vq && $stable(item_q))
    else $error("held word lost before processing");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && !out_ready_i |-> !step)
    else $error("waiting result overwritten");

endmodule

/* sv/tsa_ring.sv */
// Ring of history entries for the timestamp set assembler: entry storage,
// the current pointer, the lookup against the registered word and the update.
// Depends on tsa_pkg.
module tsa_ring #(
  parameter int unsigned RING_DEPTH = tsa_pkg::RING_DEPTH_DEF,
  parameter int unsigned TYPE_COUNT = tsa_pkg::TYPE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  tsa_pkg::item_t             item_i,
  input  logic [tsa_pkg::CFG_W-1:0]  types_in_use_i,
  input  logic [tsa_pkg::CFG_W-1:0]  history_depth_i,
  output tsa_pkg::result_t           res_o
);

  localparam int unsigned STORE_DEPTH =
    (RING_DEPTH < tsa_pkg::MAX_DEPTH) ? RING_DEPTH : tsa_pkg::MAX_DEPTH;
  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
  localparam int unsigned MASK_W =
    (TYPE_COUNT < tsa_pkg::OUT_MASK_W) ? TYPE_COUNT : tsa_pkg::OUT_MASK_W;
  localparam int unsigned TYPES_CLAMP =
    (TYPE_COUNT < tsa_pkg::MAX_TYPES) ? TYPE_COUNT : tsa_pkg::MAX_TYPES;
  localparam int unsigned CW = tsa_pkg::CFG_W;
  localparam int unsigned NEED_W = 16;

  logic [tsa_pkg::STAMP_W-1:0] stamps_q [STORE_DEPTH];
  logic [MASK_W-1:0]           masks_q  [STORE_DEPTH];
  logic [PTR_W-1:0]            cur_q;

  logic [CW-1:0] depth, types;
  logic [CW-1:0] cur, prev1, prev2, nxt, tgt;
  logic [STORE_DEPTH-1:0] eq;
  logic [tsa_pkg::STAMP_W-1:0] stamp_cur, stamp_nxt;
  logic [MASK_W-1:0] mask_nxt, mask_tgt, old_mask, new_mask, slot_bit;
  logic eq_cur, eq_prev1, eq_prev2, eq_nxt;
  logic bad, late, advance, restart, dup, complete, wr_en;
  logic [NEED_W-1:0] need;

  // Effective register values after clamping.
  always_comb begin
    if (history_depth_i == '0) begin
      depth = CW'(1);
    end else if (32'(history_depth_i) > STORE_DEPTH) begin
      depth = CW'(STORE_DEPTH);
    end else begin
      depth = history_depth_i;
    end
    if (types_in_use_i == '0) begin
      types = CW'(1);
    end else if (32'(types_in_use_i) > TYPES_CLAMP) begin
      types = CW'(TYPES_CLAMP);
    end else begin
      types = types_in_use_i;
    end
  end

  // Pointer arithmetic within the depth in use. The stored pointer may sit
  // beyond a depth that has since shrunk, so it is reduced through the table.
  always_comb begin
    cur = tsa_pkg::MOD_TABLE[{CW'(cur_q), depth}];
    prev1 = (cur == '0) ? depth - CW'(1) : cur - CW'(1);
    if (depth == CW'(1)) begin
      prev2 = cur;
    end else if (cur >= CW'(2)) begin
      prev2 = cur - CW'(2);
    end else begin
      prev2 = cur + depth - CW'(2);
    end
    nxt = (cur + CW'(1) == depth) ? '0 : cur + CW'(1);
  end

  // Every entry compares its own stamp; selections are AND-OR over entries.
  always_comb begin
    stamp_cur = '0;
    stamp_nxt = '0;
    mask_nxt  = '0;
    eq_cur    = 1'b0;
    eq_prev1  = 1'b0;
    eq_prev2  = 1'b0;
    eq_nxt    = 1'b0;
    for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
      eq[k] = (stamps_q[k] == item_i.stamp);
      if (CW'(k) == cur) begin
        stamp_cur = stamp_cur | stamps_q[k];
        eq_cur    = eq_cur | eq[k];
      end
      if (CW'(k) == nxt) begin
        stamp_nxt = stamp_nxt | stamps_q[k];
        mask_nxt  = mask_nxt | masks_q[k];
        eq_nxt    = eq_nxt | eq[k];
      end
      if (CW'(k) == prev1) begin
        eq_prev1 = eq_prev1 | eq[k];
      end
      if (CW'(k) == prev2) begin
        eq_prev2 = eq_prev2 | eq[k];
      end
    end
  end

  // Decide which entry takes the word, or flag it as a bad slot or late.
  always_comb begin
    bad     = ({1'b0, item_i.slot} >= types);
    late    = 1'b0;
    advance = 1'b0;
    restart = 1'b0;
    tgt     = cur;
    if (bad) begin
      tgt = cur;
    end else if (eq_cur) begin
      tgt = cur;
    end else if (item_i.stamp < stamp_cur) begin
      if (eq_prev1) begin
        tgt = prev1;
      end else if (eq_prev2) begin
        tgt = prev2;
      end else begin
        late = 1'b1;
      end
    end else begin
      advance = 1'b1;
      tgt     = nxt;
      restart = !eq_nxt;
    end
  end

  always_comb begin
    mask_tgt = '0;
    for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
      if (CW'(k) == tgt) begin
        mask_tgt = mask_tgt | masks_q[k];
      end
    end
    slot_bit = MASK_W'(1) << item_i.slot;
    old_mask = restart ? '0 : mask_tgt;
    dup      = |(old_mask & slot_bit);
    new_mask = old_mask | slot_bit;
    need     = (NEED_W'(1) << types) - NEED_W'(1);
    complete = ((NEED_W'(new_mask) & need) == need);
    wr_en    = !bad && !late;
  end

  always_comb begin
    res_o = '0;
    if (bad) begin
      res_o.status = tsa_pkg::ST_BAD_SLOT;
    end else if (late) begin
      res_o.status = tsa_pkg::ST_LATE;
    end else begin
      if (dup) begin
        res_o.status = tsa_pkg::ST_DUPLICATE;
      end else if (complete) begin
        res_o.status = tsa_pkg::ST_COMPLETE;
      end else begin
        res_o.status = tsa_pkg::ST_PARTIAL;
      end
      res_o.entry_index = tgt[tsa_pkg::IDX_W-1:0];
      res_o.set_mask    = tsa_pkg::OUT_MASK_W'(new_mask);
      if (restart && (stamp_nxt != '0 || mask_nxt != '0)) begin
        res_o.evicted       = 1'b1;
        res_o.evicted_stamp = stamp_nxt;
        res_o.evicted_mask  = tsa_pkg::OUT_MASK_W'(mask_nxt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
        stamps_q[k] <= '0;
        masks_q[k]  <= '0;
      end
    end else if (step_i) begin
      if (advance) begin
        cur_q <= nxt[PTR_W-1:0];
      end
      for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
        if (wr_en && CW'(k) == tgt) begin
          masks_q[k] <= new_mask;
          if (restart) begin
            stamps_q[k] <= item_i.stamp;
          end
        end
      end
    end
  end

  a_evict_only_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.evicted |-> (res_o.status == tsa_pkg::ST_PARTIAL ||
                       res_o.status == tsa_pkg::ST_COMPLETE))
    else $error("eviction reported on a word that was not stored");

  a_late_keeps_pointer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !advance |=> cur_q == $past(cur_q))
    else $error("ring pointer moved without a newer timestamp");

  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && advance |=> 32'(cur_q) < STORE_DEPTH)
    else $error("ring pointer left the stored entries");

endmodule
